@@ src/itsu_pkg.sv @@
// ----------------------------------------------------------------------------
// itsu_pkg
// Shared types, constants and byte coding for the superscript formatter.
// ----------------------------------------------------------------------------
package itsu_pkg;

	localparam int VALUE_W    = 64;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 20;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [7:0] LEAD_TWO   = 8'hC2;
	localparam logic [7:0] LEAD_THREE = 8'hE2;
	localparam logic [7:0] MID_THREE  = 8'h81;
	localparam logic [7:0] LOW_BASE   = 8'hB0;
	localparam logic [7:0] LOW_ONE    = 8'hB9;
	localparam logic [7:0] LOW_MINUS  = 8'hBB;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// Digits 1, 2 and 3 are two-byte characters, the rest take three bytes.
	function automatic logic is_short(input logic [DIGIT_W-1:0] digit);
		is_short = (digit == 4'd1) || (digit == 4'd2) || (digit == 4'd3);
	endfunction

	function automatic logic [7:0] digit_byte(input logic [DIGIT_W-1:0] digit,
		input logic [1:0] sub);
		logic [7:0] low;
		low = (digit == 4'd1) ? LOW_ONE : (LOW_BASE + {4'd0, digit});
		if (is_short(digit)) begin
			digit_byte = (sub == 2'd0) ? LEAD_TWO : low;
		end else begin
			case (sub)
				2'd0:    digit_byte = LEAD_THREE;
				2'd1:    digit_byte = MID_THREE;
				default: digit_byte = low;
			endcase
		end
	endfunction

	function automatic logic [7:0] minus_byte(input logic [1:0] sub);
		case (sub)
			2'd0:    minus_byte = LEAD_THREE;
			2'd1:    minus_byte = MID_THREE;
			default: minus_byte = LOW_MINUS;
		endcase
	endfunction

endpackage

@@ src/integer_to_superscript_utf8.sv @@
// ----------------------------------------------------------------------------
// integer_to_superscript_utf8
// Converts a signed 64-bit integer to a UTF-8 string of superscript digits.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  input    in_valid / in_stall       value[63:0], signed
//  output   out_valid / out_stall     utf8_byte[7:0], last
//
//  An input transaction runs shift-and-add-3 binary to BCD conversion through
//  a bank of 20 parallel digit adjust units, then leading zero removal, then
//  emits one output byte per cycle at best (2 to 60 bytes). The next
//  transaction can be accepted in the cycle after the final byte is registered.
//  in_stall is high from acceptance until the final byte is registered.
//  Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module integer_to_superscript_utf8 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [itsu_pkg::VALUE_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       utf8_byte,
	output logic                             last
);

	itsu_pkg::state_t state_q, state_d;

	logic [itsu_pkg::VALUE_W-1:0]   mag_q;
	logic [itsu_pkg::BCD_W-1:0]     bcd_q;
	logic [itsu_pkg::BCD_W-1:0]     bcd_adj;
	logic [itsu_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [itsu_pkg::DIG_CNT_W-1:0] dig_left_q;
	logic [1:0]                     sub_q;
	logic                           neg_q;
	logic                           out_valid_q;
	logic [7:0]                     byte_q;
	logic                           last_q;

	logic [itsu_pkg::DIGIT_W-1:0] top_digit;
	logic                         slot_free;
	logic                         emit;
	logic [7:0]                   emit_byte;
	logic                         char_end;
	logic                         emit_last;
	logic                         in_accept;

	assign top_digit = bcd_q[itsu_pkg::BCD_W-1 -: itsu_pkg::DIGIT_W];
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != itsu_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < itsu_pkg::NUM_DIGITS; i++) begin
			bcd_adj[i*itsu_pkg::DIGIT_W +: itsu_pkg::DIGIT_W] =
				(bcd_q[i*itsu_pkg::DIGIT_W +: itsu_pkg::DIGIT_W] >= 4'd5) ?
				bcd_q[i*itsu_pkg::DIGIT_W +: itsu_pkg::DIGIT_W] + 4'd3 :
				bcd_q[i*itsu_pkg::DIGIT_W +: itsu_pkg::DIGIT_W];
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_byte = itsu_pkg::minus_byte(sub_q);
		char_end  = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			itsu_pkg::ST_SIGN: begin
				emit     = slot_free;
				char_end = (sub_q == 2'd2);
			end
			itsu_pkg::ST_DIGIT: begin
				emit      = slot_free;
				emit_byte = itsu_pkg::digit_byte(top_digit, sub_q);
				char_end  = itsu_pkg::is_short(top_digit) ? (sub_q == 2'd1) : (sub_q == 2'd2);
				emit_last = char_end && (dig_left_q == itsu_pkg::DIG_CNT_W'(1));
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itsu_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = itsu_pkg::ST_CONV;
				end
			end
			itsu_pkg::ST_CONV: begin
				if (bit_cnt_q == '1) begin
					state_d = itsu_pkg::ST_SKIP;
				end
			end
			itsu_pkg::ST_SKIP: begin
				if (top_digit != '0 || dig_left_q == itsu_pkg::DIG_CNT_W'(1)) begin
					state_d = neg_q ? itsu_pkg::ST_SIGN : itsu_pkg::ST_DIGIT;
				end
			end
			itsu_pkg::ST_SIGN: begin
				if (emit && char_end) begin
					state_d = itsu_pkg::ST_DIGIT;
				end
			end
			itsu_pkg::ST_DIGIT: begin
				if (emit && emit_last) begin
					state_d = itsu_pkg::ST_IDLE;
				end
			end
			default: state_d = itsu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itsu_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			dig_left_q  <= '0;
			sub_q       <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				itsu_pkg::ST_IDLE: begin
					bit_cnt_q  <= '0;
					dig_left_q <= itsu_pkg::DIG_CNT_W'(itsu_pkg::NUM_DIGITS);
					sub_q      <= '0;
				end
				itsu_pkg::ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
				end
				itsu_pkg::ST_SKIP: begin
					if (top_digit == '0 && dig_left_q != itsu_pkg::DIG_CNT_W'(1)) begin
						dig_left_q <= dig_left_q - 1'b1;
					end
				end
				itsu_pkg::ST_SIGN: begin
					if (emit) begin
						sub_q <= char_end ? 2'd0 : sub_q + 2'd1;
					end
				end
				itsu_pkg::ST_DIGIT: begin
					if (emit) begin
						sub_q <= char_end ? 2'd0 : sub_q + 2'd1;
						if (char_end) begin
							dig_left_q <= dig_left_q - 1'b1;
						end
					end
				end
				default: begin
					sub_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			neg_q <= value[itsu_pkg::VALUE_W-1];
			mag_q <= value[itsu_pkg::VALUE_W-1] ? (itsu_pkg::VALUE_W'(0) - value) : value;
			bcd_q <= '0;
		end else if (state_q == itsu_pkg::ST_CONV) begin
			{bcd_q, mag_q} <= {bcd_adj, mag_q} << 1;
		end else if ((state_q == itsu_pkg::ST_SKIP && top_digit == '0
				&& dig_left_q != itsu_pkg::DIG_CNT_W'(1))
				|| (state_q == itsu_pkg::ST_DIGIT && emit && char_end)) begin
			bcd_q <= bcd_q << itsu_pkg::DIGIT_W;
		end
		if (emit) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign utf8_byte = byte_q;
	assign last      = last_q;

	ast_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == itsu_pkg::ST_CONV)
		else $error("Accepted transaction did not start conversion.");

	ast_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == itsu_pkg::ST_IDLE && out_valid_q && last_q)
		else $error("Final byte did not end the transaction.");

	ast_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itsu_pkg::ST_DIGIT |-> dig_left_q != '0)
		else $error("Digit emission with no digits left.");

	ast_skip_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == itsu_pkg::ST_SKIP) |-> $past(state_q) == itsu_pkg::ST_CONV
			&& $past(bit_cnt_q) == '1)
		else $error("Digit scan entered before conversion finished.");

	ast_no_emit_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !emit)
		else $error("Output register overwritten while stalled.");

endmodule

@@ tb/tb_integer_to_superscript_utf8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_superscript_utf8
// Self-checking testbench for the superscript decimal formatter. A table of
// directed values and then random values are sent with bursty input timing.
// Each output byte and its last flag are checked against table bytes or a local
// formatter; the receiver stalls at random and once holds off for a long time.
// ----------------------------------------------------------------------------
module tb_integer_to_superscript_utf8;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} glyph_byte_t;

	typedef struct packed {
		logic [63:0] num;
		logic [3:0]  typed_len;
		logic [47:0] typed_bytes;
	} value_row_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM   = 260;
	localparam int HOLD_CYCLES = 400;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic signed [63:0] value    = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        utf8_byte;
	logic              last;

	glyph_byte_t pending_bytes[$];
	glyph_byte_t head_byte;
	int          mismatch_count = 0;
	int          accepted_count = 0;
	int          burst_left;

	value_row_t directed_rows [N_DIRECTED] = '{
		'{64'd0,                          4'd3, 48'hE2_81_B0},
		'{64'd1,                          4'd2, 48'hC2_B9},
		'{64'd2,                          4'd2, 48'hC2_B2},
		'{64'd3,                          4'd2, 48'hC2_B3},
		'{64'd4,                          4'd3, 48'hE2_81_B4},
		'{64'd9,                          4'd3, 48'hE2_81_B9},
		'{64'd10,                         4'd5, 48'hC2_B9_E2_81_B0},
		'{-64'sd1,                        4'd5, 48'hE2_81_BB_C2_B9},
		'{-64'sd5,                        4'd6, 48'hE2_81_BB_E2_81_B5},
		'{64'h8000_0000_0000_0000,        4'd0, 48'h0},
		'{64'h7FFF_FFFF_FFFF_FFFF,        4'd0, 48'h0},
		'{64'h8000_0000_0000_0001,        4'd0, 48'h0},
		'{64'hFFFF_FFFF_FFFF_FFFF,        4'd0, 48'h0},
		'{64'd1000000000000000000,        4'd0, 48'h0},
		'{-64'sd1000000000000000000,      4'd0, 48'h0},
		'{64'd999999999999999999,         4'd0, 48'h0},
		'{64'd1234567890,                 4'd0, 48'h0},
		'{-64'sd9876543210,               4'd0, 48'h0},
		'{64'd123,                        4'd0, 48'h0},
		'{64'h5555_AAAA_5555_AAAA,        4'd0, 48'h0}
	};

	integer_to_superscript_utf8 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.utf8_byte (utf8_byte),
		.last      (last)
	);

	always #6 clk = ~clk;

	function automatic void predict_superscript(input logic [63:0] raw);
		logic [63:0] rest;
		logic [3:0]  digit_stack[$];
		glyph_byte_t glyph[$];
		logic [3:0]  d;
		rest = raw[63] ? 64'd0 - raw : raw;
		do begin
			digit_stack.push_front(4'(rest % 64'd10));
			rest = rest / 64'd10;
		end while (rest != 64'd0);
		if (raw[63]) begin
			glyph.push_back('{itsu_pkg::LEAD_THREE, 1'b0});
			glyph.push_back('{itsu_pkg::MID_THREE, 1'b0});
			glyph.push_back('{itsu_pkg::LOW_MINUS, 1'b0});
		end
		foreach (digit_stack[i]) begin
			d = digit_stack[i];
			case (d)
				4'd1: begin
					glyph.push_back('{itsu_pkg::LEAD_TWO, 1'b0});
					glyph.push_back('{itsu_pkg::LOW_ONE, 1'b0});
				end
				4'd2, 4'd3: begin
					glyph.push_back('{itsu_pkg::LEAD_TWO, 1'b0});
					glyph.push_back('{itsu_pkg::LOW_BASE + {4'd0, d}, 1'b0});
				end
				default: begin
					glyph.push_back('{itsu_pkg::LEAD_THREE, 1'b0});
					glyph.push_back('{itsu_pkg::MID_THREE, 1'b0});
					glyph.push_back('{itsu_pkg::LOW_BASE + {4'd0, d}, 1'b0});
				end
			endcase
		end
		glyph[glyph.size() - 1].l = 1'b1;
		foreach (glyph[i]) pending_bytes.push_back(glyph[i]);
	endfunction

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int          digits;
		int          pick;
		pick = $urandom_range(0, 9);
		v = '0;
		case (pick)
			0, 1: v = {$urandom, $urandom};
			2, 3: v = 64'($urandom_range(0, 999));
			8: begin
				v = 64'd1;
				digits = $urandom_range(0, 18);
				repeat (digits) v = v * 64'd10;
				case ($urandom_range(0, 2))
					0: v = v - 64'd1;
					2: v = v + 64'd1;
					default: ;
				endcase
			end
			9: begin
				v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
				v = v ^ 64'($urandom_range(0, 3));
			end
			default: begin
				digits = $urandom_range(1, 19);
				repeat (digits) v = v * 64'd10 + 64'($urandom_range(0, 9));
			end
		endcase
		if (pick > 1 && pick != 9 && $urandom_range(0, 1) == 1) v = 64'd0 - v;
		return v;
	endfunction

	task automatic send_value(input logic [63:0] num, input int typed_len,
		input logic [47:0] typed_bytes);
		in_valid <= 1'b1;
		value <= num;
		do @(posedge clk); while (in_stall);
		accepted_count++;
		if (typed_len == 0) begin
			predict_superscript(num);
		end else begin
			for (int k = 0; k < typed_len; k++) begin
				pending_bytes.push_back('{typed_bytes[8*(typed_len-1-k) +: 8],
					k == typed_len - 1});
			end
		end
		@(negedge clk);
	endtask

	task automatic pace_burst();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				$error("utf8_byte: unexpected transaction, actual %02h last %0b",
					utf8_byte, last);
				mismatch_count++;
			end else begin
				head_byte = pending_bytes.pop_front();
				if (utf8_byte !== head_byte.b) begin
					$error("utf8_byte: expected %02h, actual %02h", head_byte.b, utf8_byte);
					mismatch_count++;
				end
				if (last !== head_byte.l) begin
					$error("last: expected %0b, actual %0b", head_byte.l, last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		int       phase;
		bit       held;
		rx_mode = RX_FREE;
		mode_left = 0;
		phase = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && accepted_count >= 40) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				phase++;
				case (rx_mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
					RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
					default:  out_stall <= ((phase % 5) < 2);
				endcase
			end
		end
	end

	initial begin
		burst_left = $urandom_range(1, 8);
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_value(directed_rows[i].num, int'(directed_rows[i].typed_len),
				directed_rows[i].typed_bytes);
			pace_burst();
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			send_value(random_value(), 0, '0);
			pace_burst();
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("integer_to_superscript_utf8 test passed");
		end else begin
			$display("integer_to_superscript_utf8 test failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("integer_to_superscript_utf8 test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/itsu_pkg.sv
src/integer_to_superscript_utf8.sv
tb/tb_integer_to_superscript_utf8.sv
